/* rtl/fpe_pkg.sv */
// Shared field widths and the divider status type for the factorial prime exponent unit.
package fpe_pkg;

    localparam int NUMBER_W   = 64;
    localparam int PRIME_W    = 32;
    localparam int EXPONENT_W = 64;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/fpe_divider.sv */
// Restoring divider that retires one quotient bit per cycle.
module fpe_divider #(
    parameter int DIVIDEND_W = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DIVIDEND_W-1:0]      dividend,
    input  logic [fpe_pkg::PRIME_W-1:0] divisor,
    output logic [DIVIDEND_W-1:0]      quotient,
    output fpe_pkg::div_status_t       status
);
    import fpe_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [PRIME_W-1:0]    rem_reg;
    logic [PRIME_W-1:0]    div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [PRIME_W:0]      trial;
    logic                  fits;
    logic [PRIME_W:0]      trial_diff;

    // The partial remainder is shifted left by one and takes the next dividend bit.
    assign trial      = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign fits       = (trial >= {1'b0, div_reg});
    assign trial_diff = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
                rem_reg  <= fits ? trial_diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/factorial_prime_exponent_unit.sv */
// Factorial prime exponent unit: Legendre's formula over a shared restoring divider.
// Timing: a prime below two gives its result beat in the cycle after acceptance.
// Otherwise an item needs k divisions by the prime, run one after another on the divider,
// where k is the largest power with p^k <= n (at least one).
// One item at a time: the next input beat is taken no sooner than the cycle after the result beat.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops the result valid.
module factorial_prime_exponent_unit #(
    parameter int NUM_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fpe_pkg::NUMBER_W-1:0]    s_number,
    input  logic [fpe_pkg::PRIME_W-1:0]     s_prime,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fpe_pkg::EXPONENT_W-1:0]  m_exponent,
    output logic                            m_bad_prime
);
    import fpe_pkg::*;

    // Width used to compare a quotient against the prime.
    localparam int CMP_W = (NUM_BITS > PRIME_W) ? NUM_BITS : PRIME_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [PRIME_W-1:0]  prime_reg;
    logic [NUM_BITS-1:0] acc_reg;
    logic [NUM_BITS-1:0] dividend_reg;
    logic                start_reg;
    logic                m_valid_reg;
    logic                bad_prime_reg;

    logic [NUM_BITS-1:0] div_quotient;
    div_status_t         div_status;
    logic                in_beat;
    logic                prime_small;
    logic                last_term;

    // The k-th quotient floor(n / p^k) equals floor(q_(k-1) / p), so the unit divides the
    // previous quotient again rather than forming powers of p. No power is ever built, so
    // nothing can overflow. Once a quotient drops below p the next one would be zero and
    // the sum is complete.
    fpe_divider #(
        .DIVIDEND_W(NUM_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .dividend(dividend_reg),
        .divisor (prime_reg),
        .quotient(div_quotient),
        .status  (div_status)
    );

    assign in_beat     = s_valid && s_ready;
    assign prime_small = (s_prime < PRIME_W'(2));
    assign last_term   = (CMP_W'(div_quotient) < CMP_W'(prime_reg));

    // Sequencer: takes an input beat when idle, runs the divisions, then holds the result
    // beat in the output registers until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        prime_reg    <= s_prime;
                        dividend_reg <= s_number[NUM_BITS-1:0];
                        acc_reg      <= '0;
                        if (prime_small) begin
                            // A prime below two has no meaningful exponent: flag it, report zero.
                            bad_prime_reg <= 1'b1;
                            m_valid_reg   <= 1'b1;
                            state_reg     <= ST_RESULT;
                        end else begin
                            bad_prime_reg <= 1'b0;
                            start_reg     <= 1'b1;
                            state_reg     <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (div_status.done) begin
                        // The running sum never exceeds n, so it fits in NUM_BITS.
                        acc_reg <= acc_reg + div_quotient;
                        if (last_term) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= ST_RESULT;
                        end else begin
                            dividend_reg <= div_quotient;
                            start_reg    <= 1'b1;
                        end
                    end
                end
                ST_RESULT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_exponent  = EXPONENT_W'(acc_reg);
    assign m_bad_prime = bad_prime_reg;

`ifndef NO_ASSERTIONS
    // The block never takes a new beat while a result beat is still on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    // A flagged prime always carries a zero exponent.
    a_bad_prime_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_prime) |-> (m_exponent == '0))
        else $error("bad prime with non-zero exponent");

    // The divider is only started when it is free.
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !div_status.busy)
        else $error("divider restarted while busy");

    // A prime below two is answered in the very next cycle.
    a_bad_prime_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && prime_small) |=> (m_valid && m_bad_prime))
        else $error("bad prime not reported at once");
`endif

endmodule
